// ----- sv/npcl_pkg.sv -----
// Shared constants, action codes and conversion tables for the nearest palette color block.
package npcl_pkg;

    localparam int PALETTE_DEPTH_DEF     = 256;
    localparam int LAB_FRACTION_BITS_DEF = 8;
    localparam int RATIO_BITS            = 48;
    localparam int ROOT_BITS             = 16;
    localparam int LAB_INT_BITS          = 10;
    localparam int COEF_W                = 24;
    localparam int SUM_W                 = 32;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // RGB to XYZ coefficients scaled by 1e7; row is the XYZ component, col the channel
    function automatic logic [COEF_W-1:0] coef(input logic [1:0] row, input logic [1:0] col);
        logic [COEF_W-1:0] c;
        c = '0;
        case ({row, col})
            4'b0000: c = 24'd4124564;
            4'b0001: c = 24'd3575761;
            4'b0010: c = 24'd1804375;
            4'b0100: c = 24'd2126729;
            4'b0101: c = 24'd7151522;
            4'b0110: c = 24'd721750;
            4'b1000: c = 24'd193339;
            4'b1001: c = 24'd1191920;
            4'b1010: c = 24'd9503041;
            default: c = '0;
        endcase
        return c;
    endfunction

    // 255 times the white point, scaled by 1e7
    function automatic logic [SUM_W-1:0] white_den(input logic [1:0] row);
        logic [SUM_W-1:0] d;
        d = '0;
        case (row)
            2'd0:    d = 32'd2423698500;
            2'd1:    d = 32'd2550000000;
            2'd2:    d = 32'd2776516500;
            default: d = 32'd2550000000;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/npcl_conv.sv -----
// RGB to Lab converter: shared multiply-add and bit-serial cube root by cross-multiplied compare.
module npcl_conv #(
    parameter int LAB_FRACTION_BITS = npcl_pkg::LAB_FRACTION_BITS_DEF,
    parameter int LAB_W             = npcl_pkg::LAB_INT_BITS + LAB_FRACTION_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [7:0]                  i_red,
    input  logic [7:0]                  i_green,
    input  logic [7:0]                  i_blue,
    output logic                        o_done,
    output logic [2:0][LAB_W-1:0]       o_lab
);
    localparam int SH     = npcl_pkg::ROOT_BITS - LAB_FRACTION_BITS;
    localparam int R_W    = npcl_pkg::ROOT_BITS + 1;
    localparam int CUBE_W = 3 * R_W;
    localparam int LO_W   = 26;
    localparam int HI_W   = CUBE_W - LO_W;
    localparam int PROD_W = CUBE_W + npcl_pkg::SUM_W;
    localparam logic signed [27:0] LAB_MAX = 28'((64'sd1 <<< (LAB_W - 1)) - 64'sd1);
    localparam logic signed [27:0] LAB_MIN = -LAB_MAX - 28'sd1;
    localparam logic signed [27:0] HALF    = 28'(64'sd1 <<< (SH - 1));
    localparam logic signed [27:0] L_OFS   = 28'(64'sd16 <<< npcl_pkg::ROOT_BITS);

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_ROOT, S_LAB} t_state;

    t_state                           r_state;
    logic [1:0]                       r_k;
    logic [7:0]                       r_red, r_green, r_blue;
    logic [npcl_pkg::SUM_W-1:0]       r_sum;
    logic [4:0]                       r_bit;
    logic [1:0]                       r_phase;
    logic [R_W-1:0]                   r_root;
    logic [2*R_W-1:0]                 r_sq;
    logic [CUBE_W-1:0]                r_cube;
    logic [HI_W+npcl_pkg::SUM_W-1:0]  r_ph;
    logic [LO_W+npcl_pkg::SUM_W-1:0]  r_pl;
    logic [2:0][R_W-1:0]              r_f;

    logic [npcl_pkg::SUM_W-1:0]       sum;
    logic [npcl_pkg::SUM_W-1:0]       den;
    logic [R_W-1:0]                   t;
    logic [PROD_W-1:0]                prod;
    logic [PROD_W-1:0]                target;
    logic                             fits;
    logic signed [27:0]               v_l, v_a, v_b;

    function automatic logic [LAB_W-1:0] to_lab(input logic signed [27:0] v);
        logic signed [27:0] r;
        r = (v + HALF) >>> SH;
        if (r > LAB_MAX) r = LAB_MAX;
        if (r < LAB_MIN) r = LAB_MIN;
        return r[LAB_W-1:0];
    endfunction

    // t^3 * den <= sum * 2^48 picks the same root as comparing t^3 with the floored ratio
    always_comb begin
        den    = npcl_pkg::white_den(r_k);
        sum    = 32'(npcl_pkg::coef(r_k, 2'd0)) * 32'(r_red)
               + 32'(npcl_pkg::coef(r_k, 2'd1)) * 32'(r_green)
               + 32'(npcl_pkg::coef(r_k, 2'd2)) * 32'(r_blue);
        t      = r_root | (R_W'(1) << r_bit);
        prod   = PROD_W'({r_ph, LO_W'(0)}) + PROD_W'(r_pl);
        target = PROD_W'(r_sum) << npcl_pkg::RATIO_BITS;
        fits   = prod <= target;
        v_l    = 28'sd116 * $signed({11'b0, r_f[1]}) - L_OFS;
        v_a    = 28'sd500 * ($signed({11'b0, r_f[0]}) - $signed({11'b0, r_f[1]}));
        v_b    = 28'sd200 * ($signed({11'b0, r_f[1]}) - $signed({11'b0, r_f[2]}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
            r_k     <= '0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_red   <= i_red;
                        r_green <= i_green;
                        r_blue  <= i_blue;
                        r_k     <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // hold the weighted sum for the whole root search
                    r_sum   <= sum;
                    r_root  <= '0;
                    r_bit   <= 5'(npcl_pkg::ROOT_BITS);
                    r_phase <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_phase <= r_phase + 2'd1;
                    case (r_phase)
                        2'd0: r_sq <= (2*R_W)'(t) * (2*R_W)'(t);
                        2'd1: r_cube <= CUBE_W'(r_sq) * CUBE_W'(t);
                        2'd2: begin
                            r_ph <= (HI_W+npcl_pkg::SUM_W)'(r_cube[CUBE_W-1:LO_W])
                                  * (HI_W+npcl_pkg::SUM_W)'(den);
                            r_pl <= (LO_W+npcl_pkg::SUM_W)'(r_cube[LO_W-1:0])
                                  * (LO_W+npcl_pkg::SUM_W)'(den);
                        end
                        default: begin
                            if (r_bit == '0) begin
                                r_f[r_k] <= fits ? t : r_root;
                                if (r_k == 2'd2) begin
                                    r_state <= S_LAB;
                                end else begin
                                    r_k     <= r_k + 2'd1;
                                    r_state <= S_SUM;
                                end
                            end else begin
                                if (fits) r_root <= t;
                                r_bit <= r_bit - 5'd1;
                            end
                        end
                    endcase
                end
                S_LAB: begin
                    o_lab[0] <= to_lab(v_l);
                    o_lab[1] <= to_lab(v_a);
                    o_lab[2] <= to_lab(v_b);
                    o_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/npcl_cell.sv -----
// One palette cell: holds an entry and updates the passing best-match token.
module npcl_cell #(
    parameter int IDX    = 0,
    parameter int LAB_W  = 18,
    parameter int DIST_W = 43,
    parameter int IDX_W  = 8,
    parameter int CNT_W  = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CNT_W-1:0]       i_count,
    input  logic                   i_wr,
    input  logic [2:0][LAB_W-1:0]  i_wr_lab,
    input  logic                   i_vld,
    input  logic [2:0][LAB_W-1:0]  i_q,
    input  logic [DIST_W-1:0]      i_dist,
    input  logic [IDX_W-1:0]       i_idx,
    output logic                   o_vld,
    output logic [2:0][LAB_W-1:0]  o_q,
    output logic [DIST_W-1:0]      o_dist,
    output logic [IDX_W-1:0]       o_idx
);
    localparam int SQ_W = 2 * (LAB_W + 1);

    logic [2:0][LAB_W-1:0]   r_lab;
    logic signed [LAB_W:0]   diff [3];
    logic [DIST_W-1:0]       cand_dist;
    logic                    active;

    always_comb begin
        cand_dist = '0;
        for (int c = 0; c < 3; c++) begin
            diff[c] = $signed({r_lab[c][LAB_W-1], r_lab[c]}) - $signed({i_q[c][LAB_W-1], i_q[c]});
            cand_dist = cand_dist + DIST_W'(SQ_W'(diff[c] * diff[c]));
        end
        active = i_count > CNT_W'(IDX);
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && i_count == CNT_W'(IDX)) r_lab <= i_wr_lab;
        o_q <= i_q;
        if (active && cand_dist < i_dist) begin
            o_dist <= cand_dist;
            o_idx  <= IDX_W'(IDX);
        end else begin
            o_dist <= i_dist;
            o_idx  <= i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

endmodule

// ----- sv/nearest_palette_color_lab_top.sv -----
// Top level: nearest palette color search in Lab over a chain of palette cells.
// Conversion: three components, each a sum state then 17 root bits that square, cube, scale
//   by the white point and compare, then one Lab state; an append is stored as conversion ends.
// Busy holds off new transfers until an item is done; a query strobes once its token has
//   walked the whole chain.
// Clear and unused actions finish in the accept cycle. Sync active-low reset empties
//   the table; the receiver cannot stall, so every result is a one-cycle o_strobe.
module nearest_palette_color_lab_top #(
    parameter int PALETTE_DEPTH     = npcl_pkg::PALETTE_DEPTH_DEF,
    parameter int LAB_FRACTION_BITS = npcl_pkg::LAB_FRACTION_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_action,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_strobe,
    output logic [7:0] o_match_index,
    output logic       o_exact_match,
    output logic       o_table_empty
);
    localparam int LAB_W  = npcl_pkg::LAB_INT_BITS + LAB_FRACTION_BITS;
    localparam int DIST_W = 2 * LAB_FRACTION_BITS + 27;
    localparam int IDX_W  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
    localparam logic [DIST_W-1:0] CEILING =
        DIST_W'(64'd100000000) << (2 * LAB_FRACTION_BITS);

    typedef enum logic [1:0] {T_IDLE, T_CONV, T_SCAN} t_state;

    t_state                 r_state;
    npcl_pkg::t_action      r_act;
    logic [CNT_W-1:0]       r_count;
    logic                   accept;
    logic                   conv_done;
    logic [2:0][LAB_W-1:0]  conv_lab;
    logic                   wr;

    // token chain between cells
    logic                   c_vld  [PALETTE_DEPTH+1];
    logic [2:0][LAB_W-1:0]  c_q    [PALETTE_DEPTH+1];
    logic [DIST_W-1:0]      c_dist [PALETTE_DEPTH+1];
    logic [IDX_W-1:0]       c_idx  [PALETTE_DEPTH+1];

    assign busy   = r_state != T_IDLE;
    assign accept = start && !busy;
    assign wr     = conv_done && r_act == npcl_pkg::ACT_APPEND
                    && r_count < CNT_W'(PALETTE_DEPTH);

    npcl_conv #(
        .LAB_FRACTION_BITS(LAB_FRACTION_BITS),
        .LAB_W(LAB_W)
    ) u_conv (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_go(accept && (i_action == npcl_pkg::ACT_APPEND || i_action == npcl_pkg::ACT_QUERY)),
        .i_red(i_red),
        .i_green(i_green),
        .i_blue(i_blue),
        .o_done(conv_done),
        .o_lab(conv_lab)
    );

    // inject the search token at the head of the chain with the distance ceiling
    assign c_vld[0]  = conv_done && r_act == npcl_pkg::ACT_QUERY;
    assign c_q[0]    = conv_lab;
    assign c_dist[0] = CEILING;
    assign c_idx[0]  = '0;

    for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
        npcl_cell #(
            .IDX(i),
            .LAB_W(LAB_W),
            .DIST_W(DIST_W),
            .IDX_W(IDX_W),
            .CNT_W(CNT_W)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_count(r_count),
            .i_wr(wr),
            .i_wr_lab(conv_lab),
            .i_vld(c_vld[i]),
            .i_q(c_q[i]),
            .i_dist(c_dist[i]),
            .i_idx(c_idx[i]),
            .o_vld(c_vld[i+1]),
            .o_q(c_q[i+1]),
            .o_dist(c_dist[i+1]),
            .o_idx(c_idx[i+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_count  <= '0;
            r_act    <= npcl_pkg::ACT_NONE;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        r_act <= npcl_pkg::t_action'(i_action);
                        case (npcl_pkg::t_action'(i_action))
                            npcl_pkg::ACT_APPEND: r_state <= T_CONV;
                            npcl_pkg::ACT_QUERY:  r_state <= T_CONV;
                            npcl_pkg::ACT_CLEAR:  r_count <= '0;
                            default:              r_state <= T_IDLE;
                        endcase
                    end
                end
                T_CONV: begin
                    if (conv_done) begin
                        // advance the fill count on a stored append; drop it when full
                        if (wr) r_count <= r_count + CNT_W'(1);
                        r_state <= (r_act == npcl_pkg::ACT_QUERY) ? T_SCAN : T_IDLE;
                    end
                end
                T_SCAN: begin
                    if (c_vld[PALETTE_DEPTH]) begin
                        o_strobe      <= 1'b1;
                        o_match_index <= 8'(c_idx[PALETTE_DEPTH]);
                        o_exact_match <= c_dist[PALETTE_DEPTH] == '0;
                        o_table_empty <= r_count == '0;
                        r_state       <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    a_strobe_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == T_SCAN))
        else $error("result strobe without a finished scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PALETTE_DEPTH))
        else $error("fill count beyond table depth");

    a_conv_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_done |-> r_state == T_CONV)
        else $error("conversion finished outside conversion state");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_table_empty) |-> (o_match_index == 8'd0 && !o_exact_match))
        else $error("empty table result carries a match");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the nearest palette color search in Lab.
`timescale 1ns / 1ps

module testbench;

    localparam int PAL_DEPTH   = 256;
    localparam int LAB_FRAC    = 8;
    localparam int LAB_W       = 10 + LAB_FRAC;
    localparam longint LAB_HI  = (longint'(1) << (LAB_W - 1)) - 1;
    localparam longint LAB_LO  = -LAB_HI - 1;
    localparam longint unsigned FAR_LIMIT = longint'(100000000) << (2 * LAB_FRAC);
    localparam int SETTLE      = 700;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        longint l;
        longint a;
        longint b;
    } t_lab;

    typedef struct {
        logic [7:0] index;
        logic       exact;
        logic       empty;
    } t_match;

    // Tracks the palette and the queue of match results still owed by the block.
    class match_board;
        t_lab   palette[PAL_DEPTH];
        int     entries;
        t_match owed[$];
        int     errors;

        function new();
            entries = 0;
            errors  = 0;
        endfunction

        static function longint unsigned frac_ratio(longint unsigned num,
                                                    longint unsigned den);
            longint unsigned q;
            longint unsigned rem;
            q   = num / den;
            rem = num % den;
            for (int i = 0; i < npcl_pkg::RATIO_BITS; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q   = q | 1;
                end
            end
            return q;
        endfunction

        static function longint floor_cbrt(longint unsigned v);
            longint unsigned c;
            longint unsigned t;
            c = 0;
            for (int k = 16; k >= 0; k--) begin
                t = c | (longint'(1) << k);
                if (t * t * t <= v) c = t;
            end
            return longint'(c);
        endfunction

        // Round a Q16 value half up to the Lab fraction and clamp it.
        static function longint round_lab(longint v);
            longint unsigned u;
            longint r;
            u = longint'(v + (longint'(1) << 40));
            u = (u + (longint'(1) << (npcl_pkg::ROOT_BITS - LAB_FRAC - 1)))
                >> (npcl_pkg::ROOT_BITS - LAB_FRAC);
            r = longint'(u) - ((longint'(1) << 40) >>> (npcl_pkg::ROOT_BITS - LAB_FRAC));
            if (r > LAB_HI) r = LAB_HI;
            if (r < LAB_LO) r = LAB_LO;
            return r;
        endfunction

        static function t_lab rgb_to_lab(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            longint unsigned wt[3][3];
            longint unsigned white[3];
            longint unsigned sum;
            longint f[3];
            t_lab res;
            wt = '{'{4124564, 3575761, 1804375},
                   '{2126729, 7151522, 721750},
                   '{193339, 1191920, 9503041}};
            white = '{9504700, 10000000, 10888300};
            for (int k = 0; k < 3; k++) begin
                sum = wt[k][0] * r + wt[k][1] * g + wt[k][2] * b;
                f[k] = floor_cbrt(frac_ratio(sum, 255 * white[k]));
            end
            res.l = round_lab(116 * f[1] - (longint'(16) << npcl_pkg::ROOT_BITS));
            res.a = round_lab(500 * (f[0] - f[1]));
            res.b = round_lab(200 * (f[1] - f[2]));
            return res;
        endfunction

        // Apply one accepted transfer; queue the match a query owes.
        function void note(npcl_pkg::t_action act, logic [7:0] r, logic [7:0] g,
                           logic [7:0] b);
            t_lab c;
            t_match m;
            longint unsigned best_d;
            longint unsigned d;
            int best;
            case (act)
                npcl_pkg::ACT_CLEAR: entries = 0;
                npcl_pkg::ACT_APPEND: begin
                    if (entries < PAL_DEPTH) begin
                        palette[entries] = rgb_to_lab(r, g, b);
                        entries++;
                    end
                end
                npcl_pkg::ACT_QUERY: begin
                    m = '{index: 8'd0, exact: 1'b0, empty: 1'b0};
                    if (entries == 0) begin
                        m.empty = 1'b1;
                    end else begin
                        c = rgb_to_lab(r, g, b);
                        best = 0;
                        best_d = FAR_LIMIT;
                        for (int i = 0; i < entries; i++) begin
                            d = (palette[i].l - c.l) * (palette[i].l - c.l)
                              + (palette[i].a - c.a) * (palette[i].a - c.a)
                              + (palette[i].b - c.b) * (palette[i].b - c.b);
                            // strict compare keeps the lowest index on ties
                            if (d < best_d) begin
                                best_d = d;
                                best = i;
                            end
                        end
                        m.index = best[7:0];
                        m.exact = (best_d == 0);
                    end
                    owed.insert(owed.size(), m);
                end
                default: ;
            endcase
        endfunction

        function void check(logic [7:0] idx, logic exact, logic empty);
            t_match m;
            if (owed.size() == 0) begin
                $display("%0t: unexpected match strobe index=%0d exact=%0b empty=%0b",
                         $time, idx, exact, empty);
                errors++;
                return;
            end
            m = owed.pop_front();
            if (idx !== m.index) begin
                $display("%0t: match_index expected %0d actual %0d", $time, m.index, idx);
                errors++;
            end
            if (exact !== m.exact) begin
                $display("%0t: exact_match expected %0b actual %0b", $time, m.exact, exact);
                errors++;
            end
            if (empty !== m.empty) begin
                $display("%0t: table_empty expected %0b actual %0b", $time, m.empty, empty);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_action = npcl_pkg::ACT_NONE;
    logic [7:0] i_red = 8'd0;
    logic [7:0] i_green = 8'd0;
    logic [7:0] i_blue = 8'd0;
    logic       o_strobe;
    logic [7:0] o_match_index;
    logic       o_exact_match;
    logic       o_table_empty;

    match_board board = new();
    longint     cycles = 0;
    bit         gaps_on = 1'b1;
    logic [23:0] stored[$];

    nearest_palette_color_lab_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_strobe      (o_strobe),
        .o_match_index (o_match_index),
        .o_exact_match (o_exact_match),
        .o_table_empty (o_table_empty)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sample at the rising edge: note each input transfer, then check any strobed match.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note(npcl_pkg::t_action'(i_action), i_red, i_green, i_blue);
            end
            if (o_strobe) board.check(o_match_index, o_exact_match, o_table_empty);
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Present one item from the falling edge and hold it until the transfer.
    task automatic send(npcl_pkg::t_action act, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(negedge i_clk);
        start    <= 1'b1;
        i_action <= act;
        i_red    <= r;
        i_green  <= g;
        i_blue   <= b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (act == npcl_pkg::ACT_APPEND) stored.insert(stored.size(), {r, g, b});
        if (act == npcl_pkg::ACT_CLEAR) stored.delete();
        // drop start for a random gap about 22 times in a hundred
        if (gaps_on) begin
            while ($urandom_range(99) < 22) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.owed.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item(int mode);
        logic [23:0] c;
        int pick;
        pick = $urandom_range(99);
        c = 24'($urandom);
        if (pick < 44) begin
            send(npcl_pkg::ACT_APPEND, c[23:16], c[15:8], c[7:0]);
        end else if (pick < 90) begin
            // query a stored color, a slightly shifted one, or anything
            if (stored.size() != 0 && $urandom_range(2) != 0) begin
                c = stored[$urandom_range(stored.size() - 1)];
                if ($urandom_range(1)) c = c ^ (24'd1 << $urandom_range(23));
            end
            send(npcl_pkg::ACT_QUERY, c[23:16], c[15:8], c[7:0]);
        end else if (pick < 95 - mode) begin
            send(npcl_pkg::ACT_CLEAR, c[23:16], c[15:8], c[7:0]);
        end else begin
            send(npcl_pkg::ACT_NONE, c[23:16], c[15:8], c[7:0]);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, exact hit, ties, unused action, clear
        send(npcl_pkg::ACT_QUERY,  8'd0,   8'd0,   8'd0);
        send(npcl_pkg::ACT_APPEND, 8'd0,   8'd0,   8'd0);
        send(npcl_pkg::ACT_APPEND, 8'd255, 8'd255, 8'd255);
        send(npcl_pkg::ACT_APPEND, 8'd255, 8'd0,   8'd0);
        send(npcl_pkg::ACT_APPEND, 8'd0,   8'd255, 8'd0);
        send(npcl_pkg::ACT_APPEND, 8'd0,   8'd0,   8'd255);
        send(npcl_pkg::ACT_APPEND, 8'd0,   8'd255, 8'd0);
        send(npcl_pkg::ACT_QUERY,  8'd0,   8'd255, 8'd0);
        send(npcl_pkg::ACT_QUERY,  8'd255, 8'd255, 8'd255);
        send(npcl_pkg::ACT_QUERY,  8'd0,   8'd0,   8'd0);
        send(npcl_pkg::ACT_QUERY,  8'd200, 8'd10,  8'd30);
        send(npcl_pkg::ACT_QUERY,  8'd1,   8'd1,   8'd1);
        send(npcl_pkg::ACT_NONE,   8'd255, 8'd255, 8'd255);
        send(npcl_pkg::ACT_QUERY,  8'd0,   8'd0,   8'd254);
        send(npcl_pkg::ACT_CLEAR,  8'd0,   8'd0,   8'd0);
        send(npcl_pkg::ACT_QUERY,  8'd128, 8'd128, 8'd128);
        send(npcl_pkg::ACT_APPEND, 8'd170, 8'd85,  8'd170);
        send(npcl_pkg::ACT_QUERY,  8'd85,  8'd170, 8'd85);
        drain();

        // random items with clears disabled, then a white append and queries
        for (int i = 0; i < PAL_DEPTH + 4; i++) random_item(100);
        send(npcl_pkg::ACT_APPEND, 8'd255, 8'd255, 8'd255);
        send(npcl_pkg::ACT_QUERY,  8'd255, 8'd255, 8'd255);
        send(npcl_pkg::ACT_QUERY,  8'd0,   8'd0,   8'd0);
        send(npcl_pkg::ACT_CLEAR,  8'd0,   8'd0,   8'd0);

        for (int i = 0; i < 1170; i++) begin
            gaps_on = !(i >= 300 && i < 550);
            if (i % 200 == 199) drain();
            random_item(0);
        end

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
